@@ src/caa_pkg.sv @@
// ----------------------------------------------------------------------------
// caa_pkg - shared types and constants of the cascaded activity averager
// tick and result item layouts, controller commands, time index forming
// ----------------------------------------------------------------------------
package caa_pkg;

    localparam int COUNT_WIDTH_DEF  = 10;
    localparam int FRAC_BITS_DEF    = 4;

    localparam int CNT_FIELD_W      = 10;
    localparam int AVG_FIELD_W      = 14;
    localparam int MSLOT_W          = 4;
    localparam int QIDX_W           = 7;
    localparam int PIDX_W           = 7;

    localparam int MINUTE_SLOTS     = 15;
    localparam int PIECE_QUARTERS   = 8;
    localparam int PQ_SHIFT         = $clog2(PIECE_QUARTERS);
    localparam int QUARTERS_PER_DAY = 24 * 4;

    typedef struct packed {
        logic [5:0]             minute;
        logic [4:0]             hour;
        logic [2:0]             weekday;
        logic [CNT_FIELD_W-1:0] user_count;
        logic [CNT_FIELD_W-1:0] wizard_count;
    } tick_t;

    typedef struct packed {
        logic                   quarter_done;
        logic [QIDX_W-1:0]      quarter_slot;
        logic [AVG_FIELD_W-1:0] quarter_avg_users;
        logic [AVG_FIELD_W-1:0] quarter_avg_wizards;
        logic                   piece_done;
        logic [PIDX_W-1:0]      piece_slot;
        logic [AVG_FIELD_W-1:0] piece_avg_users;
        logic [AVG_FIELD_W-1:0] piece_avg_wizards;
        logic                   day_wrap;
        logic                   week_wrap;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic               capture;
        logic               min_acc;
        logic [MSLOT_W-1:0] min_idx;
        logic               qrd;
        logic               div_load;
        logic               commit;
    } cmd_t;

    typedef struct packed {
        logic [QIDX_W-1:0]  quarter;
        logic [PIDX_W-1:0]  piece;
        logic [MSLOT_W-1:0] mslot;
    } tick_idx_t;

    // quarter of day, two-hour piece of week and minute slot of a tick
    function automatic tick_idx_t tick_index(tick_t t);
        logic [4:0] hr;
        logic [5:0] mr;
        logic [1:0] qm;
        logic [2:0] wd;
        tick_idx_t  r;
        hr = (t.hour >= 5'd24) ? t.hour - 5'd24 : t.hour;
        mr = (t.minute >= 6'd60) ? t.minute - 6'd60 : t.minute;
        if (mr >= 6'd45)
            qm = 2'd3;
        else if (mr >= 6'd30)
            qm = 2'd2;
        else if (mr >= 6'd15)
            qm = 2'd1;
        else
            qm = 2'd0;
        wd = (t.weekday == 3'd7) ? 3'd0 : t.weekday;
        r.quarter = {hr, qm};
        r.piece   = ({4'b0, wd} << 3) + ({4'b0, wd} << 2) + {3'b0, hr[4:1]};
        r.mslot   = MSLOT_W'(mr - ({4'b0, qm} * 6'd15));
        return r;
    endfunction

endpackage

@@ src/caa_ctrl.sv @@
// ----------------------------------------------------------------------------
// caa_ctrl - sequencer of the cascaded activity averager
// walks the rings, starts the divider and hands the result to the output
// ----------------------------------------------------------------------------
module caa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_ready,
    output logic          result_valid,
    input  logic          result_ready,
    output caa_pkg::cmd_t cmd
);
    import caa_pkg::*;

    localparam int CNT_W = $clog2(MINUTE_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             result_valid_reg;
    logic             out_free;

    assign out_free     = !result_valid_reg || result_ready;
    assign tick_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = tick_valid && tick_ready;
        cmd.min_idx  = cnt_reg[MSLOT_W-1:0];
        cmd.min_acc  = (state_reg == S_WALK) && (cnt_reg < CNT_W'(MINUTE_SLOTS));
        cmd.qrd      = (state_reg == S_WALK) && (cnt_reg < CNT_W'(PIECE_QUARTERS));
        cmd.div_load = (state_reg == S_DIV);
        cmd.commit   = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick_valid)
                    begin
                        state_reg <= S_WALK;
                        cnt_reg   <= '0;
                    end
                end
                S_WALK:
                begin
                    // the walk ends with a step past the last minute slot, then moves to the divide
                    if (cnt_reg == CNT_W'(MINUTE_SLOTS))
                    begin
                        state_reg <= S_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_DIV:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (cmd.commit)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

endmodule

@@ src/caa_dp.sv @@
// ----------------------------------------------------------------------------
// caa_dp - datapath of the cascaded activity averager
// minute rings, quarter memory, accumulators, divide-by-15 unit, result register
// ----------------------------------------------------------------------------
module caa_dp #(
    parameter int COUNT_WIDTH = caa_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = caa_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  caa_pkg::tick_t   tick,
    input  caa_pkg::cmd_t    cmd,
    output caa_pkg::result_t result
);
    import caa_pkg::*;

    localparam int CW        = COUNT_WIDTH;
    localparam int AVG_W     = CW + FRAC_BITS;
    localparam int MSUM_W    = CW + 4;
    localparam int PSUM_W    = AVG_W + PQ_SHIFT;
    localparam int NUM_W     = MSUM_W + FRAC_BITS;
    localparam int RSH       = NUM_W + 4;
    localparam int RCP_W     = NUM_W + 1;
    localparam int PROD_W    = NUM_W + RCP_W;
    // ceil(2^RSH / 15), exact floor division by 15 for any NUM_W-bit dividend
    localparam logic [RCP_W-1:0] RECIP15 = RCP_W'(((64'd1 << RSH) + 64'd14) / 64'd15);

    // captured tick
    tick_idx_t               idx_reg;
    logic [CW-1:0]           uc_reg;
    logic [CW-1:0]           wc_reg;

    // block state
    logic                    primed_reg;
    logic [MSLOT_W-1:0]      last_mslot_reg;
    logic [QIDX_W-1:0]       last_quarter_reg;
    logic [PIDX_W-1:0]       last_piece_reg;
    logic [CW-1:0]           min_user_reg [MINUTE_SLOTS];
    logic [CW-1:0]           min_wiz_reg  [MINUTE_SLOTS];
    logic [AVG_W-1:0]        qmem_user    [QUARTERS_PER_DAY];
    logic [AVG_W-1:0]        qmem_wiz     [QUARTERS_PER_DAY];
    logic [QUARTERS_PER_DAY-1:0] qvalid_reg;

    // walk
    logic [QIDX_W-1:0]       qaddr_reg;
    logic                    qrd_dly_reg;
    logic [AVG_W-1:0]        qrd_user_reg;
    logic [AVG_W-1:0]        qrd_wiz_reg;
    logic                    qrd_valid_reg;
    logic [MSUM_W-1:0]       msum_u_reg;
    logic [MSUM_W-1:0]       msum_w_reg;
    logic [PSUM_W-1:0]       psum_u_reg;
    logic [PSUM_W-1:0]       psum_w_reg;

    // divider
    logic [NUM_W-1:0]        num_u;
    logic [NUM_W-1:0]        num_w;
    logic [PROD_W-1:0]       prod_u_reg;
    logic [PROD_W-1:0]       prod_w_reg;

    result_t                 result_reg;
    result_t                 result_next;
    logic                    piece_chg;
    logic                    quarter_chg;
    logic                    mslot_chg;
    logic [AVG_W-1:0]        q_avg_u;
    logic [AVG_W-1:0]        q_avg_w;
    logic [AVG_W-1:0]        p_avg_u;
    logic [AVG_W-1:0]        p_avg_w;

    assign num_u = NUM_W'(msum_u_reg) << FRAC_BITS;
    assign num_w = NUM_W'(msum_w_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg    <= tick_index(tick);
            uc_reg     <= CW'(tick.user_count);
            wc_reg     <= CW'(tick.wizard_count);
            qaddr_reg  <= last_quarter_reg;
            msum_u_reg <= '0;
            msum_w_reg <= '0;
            psum_u_reg <= '0;
            psum_w_reg <= '0;
        end
        else
        begin
            if (cmd.min_acc)
            begin
                msum_u_reg <= msum_u_reg + MSUM_W'(min_user_reg[cmd.min_idx]);
                msum_w_reg <= msum_w_reg + MSUM_W'(min_wiz_reg[cmd.min_idx]);
            end
            if (cmd.qrd)
                qaddr_reg <= (qaddr_reg == '0) ? QIDX_W'(QUARTERS_PER_DAY - 1)
                                               : qaddr_reg - 1'b1;
            if (qrd_dly_reg && qrd_valid_reg)
            begin
                psum_u_reg <= psum_u_reg + PSUM_W'(qrd_user_reg);
                psum_w_reg <= psum_w_reg + PSUM_W'(qrd_wiz_reg);
            end
        end

        // reciprocal multiply, quotient taken from the upper bits
        if (cmd.div_load)
        begin
            prod_u_reg <= PROD_W'(num_u) * PROD_W'(RECIP15);
            prod_w_reg <= PROD_W'(num_w) * PROD_W'(RECIP15);
        end

        if (cmd.commit)
            result_reg <= result_next;
    end

    // quarter memory, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.qrd)
        begin
            qrd_user_reg  <= qmem_user[qaddr_reg];
            qrd_wiz_reg   <= qmem_wiz[qaddr_reg];
            qrd_valid_reg <= qvalid_reg[qaddr_reg];
        end
        if (cmd.commit && primed_reg && quarter_chg)
        begin
            qmem_user[idx_reg.quarter] <= q_avg_u;
            qmem_wiz[idx_reg.quarter]  <= q_avg_w;
        end
    end

    assign piece_chg   = (idx_reg.piece != last_piece_reg);
    assign quarter_chg = (idx_reg.quarter != last_quarter_reg);
    assign mslot_chg   = (idx_reg.mslot != last_mslot_reg);
    assign q_avg_u     = AVG_W'(prod_u_reg >> RSH);
    assign q_avg_w     = AVG_W'(prod_w_reg >> RSH);
    assign p_avg_u     = AVG_W'(psum_u_reg >> PQ_SHIFT);
    assign p_avg_w     = AVG_W'(psum_w_reg >> PQ_SHIFT);

    always_comb
    begin
        result_next = '0;
        if (primed_reg)
        begin
            if (piece_chg)
            begin
                result_next.piece_done        = 1'b1;
                result_next.piece_slot        = idx_reg.piece;
                result_next.piece_avg_users   = AVG_FIELD_W'(p_avg_u);
                result_next.piece_avg_wizards = AVG_FIELD_W'(p_avg_w);
                result_next.week_wrap         = (idx_reg.piece == '0);
            end
            if (quarter_chg)
            begin
                result_next.quarter_done        = 1'b1;
                result_next.quarter_slot        = idx_reg.quarter;
                result_next.quarter_avg_users   = AVG_FIELD_W'(q_avg_u);
                result_next.quarter_avg_wizards = AVG_FIELD_W'(q_avg_w);
                result_next.day_wrap            = (idx_reg.quarter == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            last_mslot_reg   <= '0;
            last_quarter_reg <= '0;
            last_piece_reg   <= '0;
            qvalid_reg       <= '0;
            qrd_dly_reg      <= 1'b0;
            for (int i = 0; i < MINUTE_SLOTS; i++)
            begin
                min_user_reg[i] <= '0;
                min_wiz_reg[i]  <= '0;
            end
        end
        else
        begin
            qrd_dly_reg <= cmd.qrd;
            if (cmd.commit)
            begin
                if (!primed_reg)
                begin
                    primed_reg       <= 1'b1;
                    last_mslot_reg   <= idx_reg.mslot;
                    last_quarter_reg <= idx_reg.quarter;
                    last_piece_reg   <= idx_reg.piece;
                end
                else
                begin
                    if (piece_chg)
                        last_piece_reg <= idx_reg.piece;
                    if (quarter_chg)
                    begin
                        last_quarter_reg            <= idx_reg.quarter;
                        qvalid_reg[idx_reg.quarter] <= 1'b1;
                    end
                    if (mslot_chg)
                    begin
                        last_mslot_reg              <= idx_reg.mslot;
                        min_user_reg[idx_reg.mslot] <= uc_reg;
                        min_wiz_reg[idx_reg.mslot]  <= wc_reg;
                    end
                end
            end
        end
    end

    assign result = result_reg;

endmodule

@@ src/cascaded_activity_averager.sv @@
// ----------------------------------------------------------------------------
// cascaded_activity_averager - quarter-of-day and two-hour activity averages
// per-minute count rings feed quarter-of-day means, which feed two-hour means
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  tick     in         tick_valid / tick_ready    caa_pkg::tick_t
//  result   out        result_valid / result_ready caa_pkg::result_t
//
//  every tick gives exactly one result transfer
//  a tick passes from one accepted transfer to the next through the ring walk,
//  the divide-by-15 reciprocal multiply, the hand-over and the return to idle,
//  where the next tick is taken
//  reset clears the last seen indices, the minute rings and the valid bits of the
//  quarter memory at once, so there is no clearing pass
//  a stalled result sits in the output register while the next tick is taken
//  and worked on; that tick waits in its last step until the register frees
//
module cascaded_activity_averager #(
    parameter int COUNT_WIDTH = caa_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = caa_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick_valid,
    output logic             tick_ready,
    input  caa_pkg::tick_t   tick,
    output logic             result_valid,
    input  logic             result_ready,
    output caa_pkg::result_t result
);
    import caa_pkg::*;

    // commands from the sequencer; the datapath reports nothing back, as the
    // walk and divide lengths are fixed
    cmd_t cmd;

    caa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // minute rings, quarter memory and the divider live here
    caa_dp #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .cmd    (cmd),
        .result (result)
    );

    // a result is only written over once the previous one has been taken
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!result_valid || result_ready))
        else $error("result register overwritten while still held");

    // a committed result is offered on the next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("committed result not offered");

    // one tick at a time: no second transfer right after the first
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> !tick_ready)
        else $error("tick taken while another is in work");

endmodule
